// File: design/cbz_pkg.sv
// shared types, constants and the fixed-point divide of the bezier path generator
package cbz_pkg;

   // number of path points per control set, 2 to 64
   localparam int SEGMENTS = 64;
   localparam int COORD_W  = 16;
   localparam int STEP_W   = 7;
   // (b - a) * k fits in 24 signed bits for k up to 64
   localparam int PROD_W   = 24;
   localparam int QUO_W    = COORD_W + 1;
   localparam int AXES     = 2;
   localparam int CTRL_N   = 4;
   // pipeline depth from issue to output register
   localparam int PIPE_N   = 6;

   localparam bit SEG_POW2 = (SEGMENTS & (SEGMENTS - 1)) == 0;
   localparam int SEG_LOG2 = $clog2(SEGMENTS);

   // reciprocal divide for a non power of two segment count
   localparam int    DIV_N   = PROD_W - 1;
   localparam int    DIV_SH  = DIV_N + SEG_LOG2;
   localparam longint DIV_M  = ((longint'(1) << DIV_SH) + SEGMENTS - 1) / SEGMENTS;
   localparam longint DIV_OFS = longint'(SEGMENTS) * 65536;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [STEP_W-1:0]         step_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [QUO_W-1:0]   quo_type;

   // control that travels with each point through the pipeline
   typedef struct packed {
      logic     valid;
      step_type step;
      logic     last;
   } ctl_type;

   // floor(num / SEGMENTS), rounding toward minus infinity
   function automatic quo_type seg_floor_div(input prod_type num);
      logic [DIV_N:0]  biased;
      logic [63:0]     scaled;
      longint          quo;
      if (SEG_POW2) begin
         return QUO_W'(num >>> SEG_LOG2);
      end
      // bias by a multiple of SEGMENTS so the dividend is non-negative
      biased = (DIV_N + 1)'(longint'(num) + DIV_OFS);
      scaled = 64'(biased) * 64'(DIV_M);
      quo    = longint'(scaled >> DIV_SH) - 65536;
      return QUO_W'(quo);
   endfunction

endpackage

// File: design/cbz_intf.sv
// valid/ready channel interfaces for control sets and path points
interface cbz_req_if
   import cbz_pkg::*;
   ();
   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type ctrl_a_x;
   coord_type ctrl_a_y;
   coord_type ctrl_b_x;
   coord_type ctrl_b_y;
   coord_type end_x;
   coord_type end_y;

   modport source (output valid, start_x, start_y, ctrl_a_x, ctrl_a_y,
                   ctrl_b_x, ctrl_b_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, ctrl_a_x, ctrl_a_y,
                   ctrl_b_x, ctrl_b_y, end_x, end_y, output ready);
endinterface

interface cbz_rsp_if
   import cbz_pkg::*;
   ();
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   step_type  step_index;
   logic      last_point;

   modport source (output valid, point_x, point_y, step_index, last_point,
                   input ready);
   modport sink   (input valid, point_x, point_y, step_index, last_point,
                   output ready);
endinterface

// File: design/cbz_lerp.sv
// one interpolation a + floor((b - a) * k / SEGMENTS) in two register stages
module cbz_lerp
   import cbz_pkg::*;
   (
   input  logic      clock,
   input  logic      advance,
   input  coord_type a,
   input  coord_type b,
   input  step_type  k,
   output coord_type result
   );

   prod_type  diff_w;
   prod_type  k_w;
   prod_type  prod_in;
   prod_type  prod_ff;
   coord_type a_ff;
   coord_type result_in;
   coord_type result_ff;

   // stage one: scaled difference
   always_comb begin
      diff_w  = PROD_W'(b) - PROD_W'(a);
      k_w     = prod_type'({{(PROD_W-STEP_W){1'b0}}, k});
      prod_in = diff_w * k_w;
   end

   // stage two: divide by the segment count and add the base
   always_comb begin
      result_in = COORD_W'(QUO_W'(a_ff) + seg_floor_div(prod_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         a_ff      <= a;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: design/cbz_step_gen.sv
// holds the control set and issues one step k per cycle into the pipeline while it advances
module cbz_step_gen
   import cbz_pkg::*;
   (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   cbz_req_if.sink   req_chan,
   output coord_type pts[AXES][CTRL_N],
   output ctl_type   issue
   );

   coord_type pts_ff[AXES][CTRL_N];
   coord_type pts_in[AXES][CTRL_N];
   step_type  step_ff;
   step_type  step_in;
   logic      active_ff;
   logic      active_in;
   logic      last_now;
   logic      take;

   // next control set is taken while the last step of the current one issues
   always_comb begin
      last_now       = (step_ff == STEP_W'(SEGMENTS));
      req_chan.ready = !reset && (!active_ff || (advance && last_now));
      take           = req_chan.valid && req_chan.ready;
   end

   // run state and step counter
   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      if (take) begin
         active_in = 1'b1;
         step_in   = STEP_W'(1);
      end else if (advance && active_ff) begin
         step_in = step_ff + STEP_W'(1);
         if (last_now) begin
            active_in = 1'b0;
         end
      end
   end

   // control set latch
   always_comb begin
      pts_in = pts_ff;
      if (take) begin
         pts_in[0][0] = req_chan.start_x;
         pts_in[1][0] = req_chan.start_y;
         pts_in[0][1] = req_chan.ctrl_a_x;
         pts_in[1][1] = req_chan.ctrl_a_y;
         pts_in[0][2] = req_chan.ctrl_b_x;
         pts_in[1][2] = req_chan.ctrl_b_y;
         pts_in[0][3] = req_chan.end_x;
         pts_in[1][3] = req_chan.end_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ax = 0; ax < AXES; ax++) begin
            for (int c = 0; c < CTRL_N; c++) begin
               pts_ff[ax][c] <= '0;
            end
         end
      end else begin
         pts_ff <= pts_in;
      end
   end

   assign pts         = pts_ff;
   assign issue.valid = active_ff;
   assign issue.step  = step_ff;
   assign issue.last  = last_now;

endmodule

// File: design/cubic_bezier_path_generator.sv
// top level: cubic bezier path generator, de casteljau over a six stage pipeline
//
// Each accepted control set (start, ctrl_a, ctrl_b, end) produces SEGMENTS path
// points, k = 1 .. SEGMENTS at t = k/SEGMENTS, one point per cycle unless the
// result side stalls; the last one equals the end point and carries last_point.
// A new control set is taken on the cycle the final step of the previous one
// issues, so a steady stream has no gap between sets; the step counter issues
// one k per cycle while the pipeline advances. Each of the three interpolation
// levels takes two register stages (multiply, then divide and add), so a point
// passes six register stages from issue to the output. A stall on the result
// side holds the whole pipeline; nothing is dropped or repeated.
module cubic_bezier_path_generator
   import cbz_pkg::*;
   (
   input  logic      clock,
   input  logic      reset,
   cbz_req_if.sink   req_chan,
   cbz_rsp_if.source rsp_chan
   );

   coord_type pts[AXES][CTRL_N];
   coord_type lvl1[AXES][3];
   coord_type lvl2[AXES][2];
   coord_type lvl3[AXES];
   ctl_type   issue;
   ctl_type   ctl_ff[PIPE_N];
   logic      advance;

   // pipeline moves whenever the output register is empty or being taken
   assign advance = !ctl_ff[PIPE_N-1].valid || rsp_chan.ready;

   cbz_step_gen u_step_gen (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req_chan (req_chan),
      .pts      (pts),
      .issue    (issue)
   );

   // control delay line matching the interpolation stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_N; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (advance) begin
         ctl_ff[0] <= issue;
         for (int i = 1; i < PIPE_N; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // three interpolation levels per axis
   for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
      for (genvar i = 0; i < 3; i++) begin : g_lvl1
         cbz_lerp u_lerp (
            .clock   (clock),
            .advance (advance),
            .a       (pts[ax][i]),
            .b       (pts[ax][i+1]),
            .k       (issue.step),
            .result  (lvl1[ax][i])
         );
      end
      for (genvar i = 0; i < 2; i++) begin : g_lvl2
         cbz_lerp u_lerp (
            .clock   (clock),
            .advance (advance),
            .a       (lvl1[ax][i]),
            .b       (lvl1[ax][i+1]),
            .k       (ctl_ff[1].step),
            .result  (lvl2[ax][i])
         );
      end
      cbz_lerp u_lerp3 (
         .clock   (clock),
         .advance (advance),
         .a       (lvl2[ax][0]),
         .b       (lvl2[ax][1]),
         .k       (ctl_ff[3].step),
         .result  (lvl3[ax])
      );
   end

   // output register is the last interpolation stage
   assign rsp_chan.valid      = ctl_ff[PIPE_N-1].valid;
   assign rsp_chan.point_x    = lvl3[0];
   assign rsp_chan.point_y    = lvl3[1];
   assign rsp_chan.step_index = ctl_ff[PIPE_N-1].step;
   assign rsp_chan.last_point = ctl_ff[PIPE_N-1].last;

endmodule

// File: tb/testbench.sv
// self-checking testbench of the cubic bezier path generator
module testbench
   import cbz_pkg::*;
   ();

   localparam int RANDOM_SETS   = 456;
   localparam int PHASE_SETS    = 38;
   localparam int PRESSURE_HOLD = 300;
   localparam int DRAIN_CYCLES  = 24;
   localparam int MAX_IDLE      = 14;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type ctrl_a_x;
      coord_type ctrl_a_y;
      coord_type ctrl_b_x;
      coord_type ctrl_b_y;
      coord_type end_x;
      coord_type end_y;
   } control_set_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      step_type  step_index;
      logic      last_point;
   } path_point_type;

   // predicts the path points of each control set and checks them in order
   class bezier_scoreboard;
      control_set_type held_set;
      path_point_type  expected_points[$];
      int              mismatches;

      // floor of num / SEGMENTS, toward minus infinity
      function int floor_by_segments(int num);
         int q;
         q = num / SEGMENTS;
         if ((num % SEGMENTS) != 0 && num < 0)
            q = q - 1;
         return q;
      endfunction

      function int interpolate(int a, int b, int k);
         return a + floor_by_segments((b - a) * k);
      endfunction

      // three levels of de casteljau interpolation at t = k / SEGMENTS
      function coord_type curve_at(int p0, int p1, int p2, int p3, int k);
         int l0, l1, l2, m0, m1;
         l0 = interpolate(p0, p1, k);
         l1 = interpolate(p1, p2, k);
         l2 = interpolate(p2, p3, k);
         m0 = interpolate(l0, l1, k);
         m1 = interpolate(l1, l2, k);
         return coord_type'(interpolate(m0, m1, k));
      endfunction

      function void note_control_set(control_set_type s);
         path_point_type p;
         held_set = s;
         for (int k = 1; k <= SEGMENTS; k++) begin
            p.point_x    = curve_at(held_set.start_x, held_set.ctrl_a_x,
                                    held_set.ctrl_b_x, held_set.end_x, k);
            p.point_y    = curve_at(held_set.start_y, held_set.ctrl_a_y,
                                    held_set.ctrl_b_y, held_set.end_y, k);
            p.step_index = step_type'(k);
            p.last_point = (k == SEGMENTS);
            expected_points = {expected_points, p};
         end
      endfunction

      function void check_point(path_point_type got);
         path_point_type want;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected point: x=%0d y=%0d k=%0d last=%0b",
                        got.point_x, got.point_y, got.step_index, got.last_point);
            return;
         end
         want = expected_points.pop_front();
         if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
             got.step_index !== want.step_index ||
             got.last_point !== want.last_point) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("point mismatch: expected x=%0d y=%0d k=%0d last=%0b,",
                        want.point_x, want.point_y, want.step_index, want.last_point,
                        " got x=%0d y=%0d k=%0d last=%0b",
                        got.point_x, got.point_y, got.step_index, got.last_point);
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   cbz_req_if req_bus ();
   cbz_rsp_if rsp_bus ();

   cubic_bezier_path_generator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   bezier_scoreboard path_board = new;

   // idle controls of the sender and the receiver
   bit send_idle;
   bit rsp_idle;
   bit hold_request;

   // clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // known values on every input from time zero
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.start_x  = '0;
      req_bus.start_y  = '0;
      req_bus.ctrl_a_x = '0;
      req_bus.ctrl_a_y = '0;
      req_bus.ctrl_b_x = '0;
      req_bus.ctrl_b_y = '0;
      req_bus.end_x    = '0;
      req_bus.end_y    = '0;
      rsp_bus.ready    = 1'b0;
   end

   function automatic control_set_type make_set(int x0, int y0, int x1, int y1,
                                                int x2, int y2, int x3, int y3);
      control_set_type s;
      s.start_x  = coord_type'(x0);
      s.start_y  = coord_type'(y0);
      s.ctrl_a_x = coord_type'(x1);
      s.ctrl_a_y = coord_type'(y1);
      s.ctrl_b_x = coord_type'(x2);
      s.ctrl_b_y = coord_type'(y2);
      s.end_x    = coord_type'(x3);
      s.end_y    = coord_type'(y3);
      return s;
   endfunction

   // a coordinate biased toward extremes and small values
   function automatic coord_type random_coord();
      case ($urandom_range(0, 7))
         0: return coord_type'(32767);
         1: return coord_type'(-32768);
         2: return coord_type'(int'($urandom_range(0, 15)) - 8);
         3: return coord_type'(32767 - int'($urandom_range(0, 70)));
         4: return coord_type'(-32768 + int'($urandom_range(0, 70)));
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic control_set_type random_set();
      return make_set(random_coord(), random_coord(), random_coord(), random_coord(),
                      random_coord(), random_coord(), random_coord(), random_coord());
   endfunction

   // offer one control set; entered and left at a falling edge
   task automatic send_control_set(input control_set_type s);
      int gap;
      gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.start_x  <= s.start_x;
      req_bus.start_y  <= s.start_y;
      req_bus.ctrl_a_x <= s.ctrl_a_x;
      req_bus.ctrl_a_y <= s.ctrl_a_y;
      req_bus.ctrl_b_x <= s.ctrl_b_x;
      req_bus.ctrl_b_y <= s.ctrl_b_y;
      req_bus.end_x    <= s.end_x;
      req_bus.end_y    <= s.end_y;
      do @(posedge clock); while (!req_bus.ready);
      path_board.note_control_set(s);
      @(negedge clock);
   endtask

   // receiver: random stalls per point, plus one long hold on request
   initial begin
      int wait_n;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (PRESSURE_HOLD) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            wait_n = rsp_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (wait_n > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (wait_n) @(negedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // result monitor
   always @(posedge clock) begin
      path_point_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.point_x    = rsp_bus.point_x;
         got.point_y    = rsp_bus.point_y;
         got.step_index = rsp_bus.step_index;
         got.last_point = rsp_bus.last_point;
         path_board.check_point(got);
      end
   end

   // stimulus and end of run
   initial begin
      send_idle    = 1'b0;
      rsp_idle     = 1'b0;
      hold_request = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, straight lines, floor on negative differences
      send_control_set(make_set(0, 0, 0, 0, 0, 0, 0, 0));
      send_control_set(make_set(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_control_set(make_set(-32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, -32768));
      send_control_set(make_set(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768));
      send_control_set(make_set(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767));
      send_control_set(make_set(-30000, 30000, -10000, 10000, 10000, -10000, 30000, -30000));
      send_control_set(make_set(0, 0, -1, 1, -3, 3, -5, 5));
      send_control_set(make_set(0, 0, 1, -1, 3, -3, 5, -5));
      send_control_set(make_set(-1, -1, -1, -1, -1, -1, -1, -1));
      send_control_set(make_set(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                                16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));
      send_control_set(make_set(32767, 32767, -32768, -32768, -32768, -32768, -32768, -32768));
      send_control_set(make_set(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
      send_control_set(make_set(100, -200, -32768, 32767, 32767, -32768, 100, -200));
      send_control_set(make_set(7, -7, 13, -13, -29, 29, 63, -63));

      // random sets in phases with different idling on each side
      for (int n = 0; n < RANDOM_SETS; n++) begin
         if (n % PHASE_SETS == 0) begin
            send_idle = 1'($urandom_range(0, 1));
            rsp_idle  = 1'($urandom_range(0, 1));
            // long receiver hold while the sender keeps offering
            if (n == 2 * PHASE_SETS) begin
               send_idle    = 1'b0;
               hold_request = 1'b1;
            end
         end
         send_control_set(random_set());
      end
      req_bus.valid <= 1'b0;

      while (path_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (path_board.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(8 * 4000000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: files.f
design/cbz_pkg.sv
design/cbz_intf.sv
design/cbz_lerp.sv
design/cbz_step_gen.sv
design/cubic_bezier_path_generator.sv
tb/testbench.sv
